// ===== design/rsf_pkg.sv =====
// ----------------------------------------------------------------------------
// rsf_pkg
// Shared codes and controller/datapath interface types for the
// replay sequence filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsf_pkg;

    localparam int ENTRIES_DEF = 8;

    localparam logic [1:0] ACT_CHECK  = 2'd0;
    localparam logic [1:0] ACT_ACCEPT = 2'd1;
    localparam logic [1:0] ACT_INIT   = 2'd2;
    localparam logic [1:0] ACT_SET    = 2'd3;

    localparam logic [2:0] DEC_EXECUTE   = 3'd0;
    localparam logic [2:0] DEC_INVALID   = 3'd1;
    localparam logic [2:0] DEC_IGNORE    = 3'd2;
    localparam logic [2:0] DEC_DUPLICATE = 3'd3;
    localparam logic [2:0] DEC_REPLAY    = 3'd4;

    typedef struct packed {
        logic capture;
        logic scan_clr;
        logic scan_inc;
        logic do_setup;
        logic fin_invalid;
        logic fin_hit;
        logic fin_ignore;
    } t_dp_cmd;

    typedef struct packed {
        logic is_judge;
        logic pkt_ok;
        logic hit;
        logic scan_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== design/rsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsf_ctrl
// Sequencer: takes a beat, dispatches set-up, an invalid-packet finish or a table scan, ends the item.
// ----------------------------------------------------------------------------
`default_nettype none

module rsf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output logic                 o_busy,
    input  rsf_pkg::t_dp_sts     i_sts,
    output rsf_pkg::t_dp_cmd     o_cmd
);
    import rsf_pkg::*;

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_DISPATCH = 2'd1;
    localparam logic [1:0] S_READ     = 2'd2;
    localparam logic [1:0] S_CMP      = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_sts.is_judge) begin
                    o_cmd.do_setup = 1'b1;
                    n_state        = S_IDLE;
                end else if (!i_sts.pkt_ok) begin
                    o_cmd.fin_invalid = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.fin_hit = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_sts.scan_last) begin
                    o_cmd.fin_ignore = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_start_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_DISPATCH))
        else $error("accepted beat did not reach dispatch");

    a_hit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && i_sts.hit) |=> (r_state == S_IDLE))
        else $error("table hit did not end the item");

    a_one_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.do_setup, o_cmd.fin_invalid, o_cmd.fin_hit, o_cmd.fin_ignore}))
        else $error("more than one finish command");

endmodule

`default_nettype wire

// ===== design/rsf_dp.sv =====
// ----------------------------------------------------------------------------
// rsf_dp
// Datapath: beat registers, device table, scan pointer, decision and result.
// ----------------------------------------------------------------------------
`default_nettype none

module rsf_dp #(
    parameter int ENTRIES = rsf_pkg::ENTRIES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [1:0]      i_action,
    input  wire logic [2:0]      i_entry_index,
    input  wire logic [31:0]     i_dev_id,
    input  wire logic [31:0]     i_sequence_req,
    input  wire logic            i_packet_valid,
    input  wire logic            i_is_command,
    input  wire logic            i_sequence_none,
    input  rsf_pkg::t_dp_cmd     i_cmd,
    output rsf_pkg::t_dp_sts     o_sts,
    output logic                 o_valid,
    output logic [2:0]           o_decision,
    output logic                 o_accepted
);
    import rsf_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [1:0]   r_action;
    logic [2:0]   r_eidx;
    logic [31:0]  r_dev;
    logic [31:0]  r_seq;
    logic         r_pvalid;
    logic         r_iscmd;
    logic         r_none;

    logic [IW-1:0] r_scan;
    logic [31:0]   r_rd_dev;
    logic [31:0]   r_rd_seq;

    logic [31:0]  mem_dev [ENTRIES];
    logic [31:0]  mem_seq [ENTRIES];
    logic [ENTRIES-1:0] r_in_use;
    logic [ENTRIES-1:0] r_has_seq;

    logic         r_strobe;
    logic [2:0]   r_decision;
    logic         r_accepted;

    logic          in_range;
    logic [IW-1:0] set_addr;
    logic          has;
    logic          exe;
    logic [2:0]    hit_dec;
    logic          acc_wr;
    logic          seq_we;
    logic [IW-1:0] seq_addr;
    logic [31:0]   seq_wdata;
    logic          n_strobe;
    logic [2:0]    n_decision;
    logic          n_accepted;

    assign in_range = (32'(r_eidx) < ENTRIES);
    assign set_addr = IW'(r_eidx);

    assign o_sts.is_judge  = (r_action == ACT_CHECK) || (r_action == ACT_ACCEPT);
    assign o_sts.pkt_ok    = r_pvalid && r_iscmd;
    assign o_sts.hit       = r_in_use[r_scan] && (r_rd_dev == r_dev);
    assign o_sts.scan_last = (r_scan == IW'(ENTRIES - 1));

    assign has = r_has_seq[r_scan];
    assign exe = !has || (r_seq > r_rd_seq);

    always_comb begin
        if (exe) begin
            hit_dec = DEC_EXECUTE;
        end else if (r_seq == r_rd_seq) begin
            hit_dec = DEC_DUPLICATE;
        end else begin
            hit_dec = DEC_REPLAY;
        end
    end

    assign acc_wr = i_cmd.fin_hit && (r_action == ACT_ACCEPT) && exe;

    always_comb begin
        seq_we    = 1'b0;
        seq_addr  = r_scan;
        seq_wdata = r_seq;
        if (i_cmd.do_setup && in_range) begin
            seq_we    = 1'b1;
            seq_addr  = set_addr;
            seq_wdata = (r_action == ACT_INIT || r_none) ? 32'd0 : r_seq;
        end else if (acc_wr) begin
            seq_we = 1'b1;
        end
    end

    always_comb begin
        n_strobe   = 1'b0;
        n_decision = DEC_EXECUTE;
        n_accepted = 1'b0;
        if (i_cmd.do_setup) begin
            n_strobe = 1'b1;
        end else if (i_cmd.fin_invalid) begin
            n_strobe   = 1'b1;
            n_decision = DEC_INVALID;
        end else if (i_cmd.fin_ignore) begin
            n_strobe   = 1'b1;
            n_decision = DEC_IGNORE;
        end else if (i_cmd.fin_hit) begin
            n_strobe   = 1'b1;
            n_decision = hit_dec;
            n_accepted = acc_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_eidx   <= i_entry_index;
            r_dev    <= i_dev_id;
            r_seq    <= i_sequence_req;
            r_pvalid <= i_packet_valid;
            r_iscmd  <= i_is_command;
            r_none   <= i_sequence_none;
        end
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + 1'b1;
        end
        r_decision <= n_decision;
        r_accepted <= n_accepted;
    end

    // device table: id and sequence arrays, each with one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_setup && in_range && r_action == ACT_INIT) begin
            mem_dev[set_addr] <= r_dev;
        end
        if (seq_we) begin
            mem_seq[seq_addr] <= seq_wdata;
        end
        r_rd_dev <= mem_dev[r_scan];
        r_rd_seq <= mem_seq[r_scan];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use  <= '0;
            r_has_seq <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            if (i_cmd.do_setup && in_range) begin
                if (r_action == ACT_INIT) begin
                    r_in_use[set_addr]  <= 1'b1;
                    r_has_seq[set_addr] <= 1'b0;
                end else begin
                    r_has_seq[set_addr] <= !r_none;
                end
            end else if (acc_wr) begin
                r_has_seq[r_scan] <= 1'b1;
            end
        end
    end

    assign o_valid    = r_strobe;
    assign o_decision = r_decision;
    assign o_accepted = r_accepted;

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(i_cmd.do_setup || i_cmd.fin_invalid
                           || i_cmd.fin_hit || i_cmd.fin_ignore))
        else $error("result beat without a finish command");

    a_acc_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_accepted) |-> (r_decision == DEC_EXECUTE))
        else $error("accepted beat not an execute decision");

    a_acc_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_accepted) |-> r_has_seq[r_scan])
        else $error("accepted sequence not recorded");

endmodule

`default_nettype wire

// ===== design/replay_sequence_filter.sv =====
// ----------------------------------------------------------------------------
// replay_sequence_filter
// Per-device anti-replay filter: table lookup of device id and monotonic
// sequence check, with set-up actions for the table.
// ----------------------------------------------------------------------------
// A beat is taken when i_start is high and o_busy is low. Every beat yields
// one result, shown for one cycle with o_valid; the receiver cannot stall it.
// Set-up actions and invalid packets are decided in the dispatch state and
// go straight to the result register; a check or accept walks the device
// table one entry at a time (memory read, then compare), stopping at the
// first matching entry, or after the last entry when nothing matches.
// The next beat may be taken in the cycle the result is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module replay_sequence_filter #(
    parameter int ENTRIES = rsf_pkg::ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [2:0]  i_entry_index,
    input  wire logic [31:0] i_dev_id,
    input  wire logic [31:0] i_sequence_req,
    input  wire logic        i_packet_valid,
    input  wire logic        i_is_command,
    input  wire logic        i_sequence_none,
    output logic             o_valid,
    output logic [2:0]       o_decision,
    output logic             o_accepted
);
    import rsf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    rsf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rsf_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_action        (i_action),
        .i_entry_index   (i_entry_index),
        .i_dev_id        (i_dev_id),
        .i_sequence_req  (i_sequence_req),
        .i_packet_valid  (i_packet_valid),
        .i_is_command    (i_is_command),
        .i_sequence_none (i_sequence_none),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_decision      (o_decision),
        .o_accepted      (o_accepted)
    );

endmodule

`default_nettype wire
